/* hw/rtl/nat_probe_peer_scheduler_assert.svh */
// assertion macros for the probe peer scheduler
`ifndef NAT_PROBE_PEER_SCHEDULER_ASSERT_SVH
`define NAT_PROBE_PEER_SCHEDULER_ASSERT_SVH

// condition implies consequence in the same cycle
`define NPPS_ASSERT_NOW(lbl, pre, post) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (pre) |-> (post)) \
        else $error("npps assertion failed");

// condition implies consequence in the next cycle
`define NPPS_ASSERT_NEXT(lbl, pre, post) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (pre) |=> (post)) \
        else $error("npps assertion failed");

`endif

/* hw/rtl/npps_pkg.sv */
// package with constants and types of the probe peer scheduler
`default_nettype none
package npps_pkg;
    localparam int DEF_PEER_SLOTS     = 16;
    localparam int DEF_RATE_FRAC_BITS = 16;

    localparam logic [1:0] OP_TICK     = 2'd0;
    localparam logic [1:0] OP_ADD      = 2'd1;
    localparam logic [1:0] OP_RESPONSE = 2'd2;
    localparam logic [1:0] OP_NOP      = 2'd3;

    localparam logic [2:0]  MAX_FAILS     = 3'd3;
    localparam logic [2:0]  FAIL_SAT      = 3'd7;
    localparam logic [31:0] SEND_GAP      = 32'd5;
    localparam logic [15:0] PERIOD_RESET  = 16'd15;
    localparam logic [4:0]  MIN_PEERS     = 5'd5;

    typedef struct packed {
        logic [31:0] addr;
        logic [15:0] port;
        logic [31:0] refl_addr;
        logic [15:0] refl_port;
        logic        refl_public;
        logic [2:0]  fails;
        logic [31:0] last_send;
        logic        answered;
    } entry_t;
endpackage
`default_nettype wire

/* hw/rtl/nat_probe_peer_scheduler.sv */
// probe peer scheduler: peer ring, probe choice and external address tracking
//
//  channel  dir  handshake          contents
//  s_       in   s_valid/s_ready    operation, time, peer, reflected address
//  m_       out  m_valid/m_ready    probe choice, add flags, external view, count
//  apb      in   psel/penable       target_period at byte address 0
//
// one item at a time; the ring sits in a memory with one read and one write port
// a tick first checks whether a probe is due once an address is known, then walks the ring
// entries when one is due or no address is known yet; the rate decays when a peer is chosen
// add searches the entries; response searches them, then checks entries for the external address
// ready again in the cycle after the result is loaded; a result not yet taken holds the block
// reset is synchronous; the memory needs no clearing, entries are only read once written
`default_nettype none
`include "nat_probe_peer_scheduler_assert.svh"
module nat_probe_peer_scheduler #(
    parameter int PEER_SLOTS     = npps_pkg::DEF_PEER_SLOTS,
    parameter int RATE_FRAC_BITS = npps_pkg::DEF_RATE_FRAC_BITS
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_valid,
    output logic             s_ready,
    input  wire logic [1:0]  s_operation,
    input  wire logic [31:0] s_now_seconds,
    input  wire logic [31:0] s_peer_addr,
    input  wire logic [15:0] s_peer_port,
    input  wire logic [31:0] s_reflected_addr,
    input  wire logic [15:0] s_reflected_port,
    input  wire logic        s_reflected_public,
    output logic             m_valid,
    input  wire logic        m_ready,
    output logic             m_probe_send,
    output logic [31:0]      m_probe_addr,
    output logic [15:0]      m_probe_port,
    output logic             m_peer_added,
    output logic             m_table_full,
    output logic             m_ext_valid,
    output logic             m_ext_stable,
    output logic [31:0]      m_ext_addr_out,
    output logic [15:0]      m_ext_port_out,
    output logic [4:0]       m_peer_count,
    output logic             m_need_peers,
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [2:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic [31:0]      prdata,
    output logic             pready
);
    localparam int IW  = (PEER_SLOTS > 1) ? $clog2(PEER_SLOTS) : 1;
    localparam int CW  = $clog2(PEER_SLOTS + 1);
    localparam int SW  = CW + 1;
    localparam int RW  = RATE_FRAC_BITS + 1;
    localparam int MBW = (RATE_FRAC_BITS > 16) ? RATE_FRAC_BITS : 16;
    localparam int PW  = RW + 1 + MBW;
    localparam logic [RW:0] RATE_ONE = (RW + 1)'(1) << RATE_FRAC_BITS;
    localparam longint RATE_FACTOR_I = (9 * (64'd1 << RATE_FRAC_BITS) + 5) / 10;
    localparam logic [MBW-1:0] RATE_FACTOR = MBW'(RATE_FACTOR_I);
    localparam logic [RW:0] RATE_GAIN = RATE_ONE - (RW + 1)'(RATE_FACTOR_I);

    localparam logic [3:0] S_IDLE    = 4'd0;
    localparam logic [3:0] S_DECODE  = 4'd1;
    localparam logic [3:0] S_DUE_MUL = 4'd2;
    localparam logic [3:0] S_DUE_CMP = 4'd3;
    localparam logic [3:0] S_WRD     = 4'd4;
    localparam logic [3:0] S_WEV     = 4'd5;
    localparam logic [3:0] S_DECAY   = 4'd6;
    localparam logic [3:0] S_SRD     = 4'd7;
    localparam logic [3:0] S_SEV     = 4'd8;
    localparam logic [3:0] S_RESP    = 4'd9;
    localparam logic [3:0] S_XRD     = 4'd10;
    localparam logic [3:0] S_XEV     = 4'd11;
    localparam logic [3:0] S_DONE    = 4'd12;

    function automatic logic [IW-1:0] slot_at(input logic [IW-1:0] h, input logic [CW-1:0] k);
        logic [SW-1:0] s;
        s = SW'(h) + SW'(k);
        if (s >= SW'(PEER_SLOTS)) s = s - SW'(PEER_SLOTS);
        return s[IW-1:0];
    endfunction

    function automatic logic [IW-1:0] inc_head(input logic [IW-1:0] h);
        if (h == IW'(PEER_SLOTS - 1)) return '0;
        return h + IW'(1);
    endfunction

    npps_pkg::entry_t mem [PEER_SLOTS];
    npps_pkg::entry_t rd_data_reg;
    npps_pkg::entry_t wr_data;
    npps_pkg::entry_t e;
    logic [IW-1:0] rd_addr, wr_addr;
    logic          wr_en;

    logic [3:0]    state_reg, state_next;
    logic [IW-1:0] head_reg, head_next;
    logic [CW-1:0] count_reg, count_next;
    logic [CW-1:0] k_reg, k_next;
    logic [RW-1:0] rate_reg, rate_next;
    logic [31:0]   lrt_reg, lrt_next;
    logic          known_reg, known_next;
    logic          stable_reg, stable_next;
    logic [31:0]   kaddr_reg, kaddr_next;
    logic [15:0]   kport_reg, kport_next;
    logic [31:0]   ktime_reg, ktime_next;
    logic [15:0]   period_reg;
    logic [1:0]    op_reg;
    logic [31:0]   now_reg, paddr_reg, raddr_reg;
    logic [15:0]   pport_reg, rport_reg;
    logic          rpub_reg;
    logic          hit_reg, hit_next;
    logic [31:0]   p1addr_reg, p1addr_next;
    logic [15:0]   p1port_reg, p1port_next;
    logic [PW-1:0] prod_reg, prod_next;
    logic          res_send_reg, res_send_next;
    logic [31:0]   res_addr_reg, res_addr_next;
    logic [15:0]   res_port_reg, res_port_next;
    logic          res_added_reg, res_added_next;
    logic          res_full_reg, res_full_next;
    logic          m_valid_reg;
    logic          m_probe_send_reg, m_peer_added_reg, m_table_full_reg;
    logic          m_ext_valid_reg, m_ext_stable_reg, m_need_peers_reg;
    logic [31:0]   m_probe_addr_reg, m_ext_ip_reg;
    logic [15:0]   m_probe_port_reg, m_ext_port_reg;
    logic [4:0]    m_peer_count_reg;
    logic          out_load;

    logic [RW:0]     mul_a;
    logic [MBW-1:0]  mul_b;
    logic [32:0]     due_time;
    logic            match;
    logic [CW-1:0]   k_inc;
    logic [31:0]     age;
    logic signed [32:0] age_x, two_t;
    logic [RW:0]     rate_sum;
    logic [31:0]     k_age;
    logic            ext_ok;
    logic signed [32:0] kage_x;

    logic s_acc;
    assign s_acc = s_valid && s_ready;
    assign s_ready = (state_reg == S_IDLE);
    assign pready = 1'b1;
    assign prdata = paddr[2] ? 32'd0 : {16'd0, period_reg};

    assign e       = rd_data_reg;
    assign match   = (e.addr == paddr_reg) && (e.port == pport_reg);
    assign k_inc   = k_reg + CW'(1);
    assign age     = now_reg - e.last_send;
    assign age_x   = {age[31], age};
    assign two_t   = {16'd0, period_reg, 1'b0};
    assign k_age   = now_reg - ktime_reg;
    assign kage_x  = {k_age[31], k_age};
    assign ext_ok  = known_reg && !(kage_x > two_t);
    assign due_time = {1'b0, lrt_reg} + 33'(prod_reg >> (RATE_FRAC_BITS + 1));
    assign rate_sum = {1'b0, rate_reg} + RATE_GAIN;
    assign out_load = (state_reg == S_DONE) && (!m_valid_reg || m_ready);

    always_comb begin
        if (state_reg == S_DECAY) begin
            mul_a = {1'b0, rate_reg};
            mul_b = RATE_FACTOR;
        end else begin
            mul_a = RATE_ONE + (RW + 1)'(rate_reg);
            mul_b = MBW'(period_reg);
        end
    end

    always_comb begin
        state_next    = state_reg;
        head_next     = head_reg;
        count_next    = count_reg;
        k_next        = k_reg;
        rate_next     = rate_reg;
        lrt_next      = lrt_reg;
        known_next    = known_reg;
        stable_next   = stable_reg;
        kaddr_next    = kaddr_reg;
        kport_next    = kport_reg;
        ktime_next    = ktime_reg;
        hit_next      = hit_reg;
        p1addr_next   = p1addr_reg;
        p1port_next   = p1port_reg;
        prod_next     = prod_reg;
        res_send_next = res_send_reg;
        res_addr_next = res_addr_reg;
        res_port_next = res_port_reg;
        res_added_next = res_added_reg;
        res_full_next = res_full_reg;
        rd_addr       = head_reg;
        wr_en         = 1'b0;
        wr_addr       = slot_at(head_reg, count_reg);
        wr_data       = e;
        case (state_reg)
            S_IDLE: begin
                if (s_acc) begin
                    state_next     = S_DECODE;
                    k_next         = '0;
                    hit_next       = 1'b0;
                    res_send_next  = 1'b0;
                    res_addr_next  = '0;
                    res_port_next  = '0;
                    res_added_next = 1'b0;
                    res_full_next  = 1'b0;
                end
            end
            S_DECODE: begin
                case (op_reg)
                    npps_pkg::OP_TICK: begin
                        if (period_reg == '0) state_next = S_DONE;
                        else if (known_reg) state_next = S_DUE_MUL;
                        else if (count_reg == '0) state_next = S_DONE;
                        else state_next = S_WRD;
                    end
                    npps_pkg::OP_ADD: begin
                        if (period_reg == '0) state_next = S_DONE;
                        else if (count_reg == '0) begin
                            wr_en = 1'b1;
                            wr_data = '{addr: paddr_reg, port: pport_reg, default: '0};
                            count_next = count_reg + CW'(1);
                            res_added_next = 1'b1;
                            state_next = S_DONE;
                        end else state_next = S_SRD;
                    end
                    npps_pkg::OP_RESPONSE: begin
                        state_next = (count_reg == '0) ? S_RESP : S_SRD;
                    end
                    default: state_next = S_DONE;
                endcase
            end
            S_DUE_MUL: begin
                prod_next  = PW'(mul_a * mul_b);
                state_next = S_DUE_CMP;
            end
            S_DUE_CMP: begin
                if ({1'b0, now_reg} >= due_time && count_reg != '0) state_next = S_WRD;
                else state_next = S_DONE;
            end
            S_WRD: begin
                rd_addr    = head_reg;
                state_next = S_WEV;
            end
            S_WEV: begin
                head_next = inc_head(head_reg);
                k_next    = k_inc;
                if (e.fails > npps_pkg::MAX_FAILS) begin
                    count_next = count_reg - CW'(1);
                    state_next = (k_inc < count_reg - CW'(1)) ? S_WRD : S_DONE;
                end else if ($signed(age) < $signed(npps_pkg::SEND_GAP)) begin
                    wr_en = 1'b1;
                    state_next = (k_inc < count_reg) ? S_WRD : S_DONE;
                end else begin
                    wr_en = 1'b1;
                    if (e.fails < npps_pkg::FAIL_SAT) wr_data.fails = e.fails + 3'd1;
                    wr_data.last_send = now_reg;
                    res_send_next = 1'b1;
                    res_addr_next = e.addr;
                    res_port_next = e.port;
                    state_next    = S_DECAY;
                end
            end
            S_DECAY: begin
                rate_next  = RW'(PW'(mul_a * mul_b) >> RATE_FRAC_BITS);
                state_next = S_DONE;
            end
            S_SRD: begin
                rd_addr    = slot_at(head_reg, k_reg);
                state_next = S_SEV;
            end
            S_SEV: begin
                k_next = k_inc;
                if (match) begin
                    if (op_reg == npps_pkg::OP_RESPONSE) begin
                        wr_en   = 1'b1;
                        wr_addr = slot_at(head_reg, k_reg);
                        wr_data.fails       = '0;
                        wr_data.refl_addr   = raddr_reg;
                        wr_data.refl_port   = rport_reg;
                        wr_data.refl_public = rpub_reg;
                        wr_data.answered    = 1'b1;
                        state_next = S_RESP;
                    end else state_next = S_DONE;
                end else if (k_inc < count_reg) begin
                    state_next = S_SRD;
                end else if (op_reg == npps_pkg::OP_RESPONSE) begin
                    state_next = S_RESP;
                end else if (count_reg >= CW'(PEER_SLOTS)) begin
                    res_full_next = 1'b1;
                    state_next = S_DONE;
                end else begin
                    wr_en = 1'b1;
                    wr_data = '{addr: paddr_reg, port: pport_reg, default: '0};
                    count_next = count_reg + CW'(1);
                    res_added_next = 1'b1;
                    state_next = S_DONE;
                end
            end
            S_RESP: begin
                rate_next  = (rate_sum > RATE_ONE) ? RW'(RATE_ONE) : RW'(rate_sum);
                lrt_next   = now_reg;
                k_next     = count_reg;
                hit_next   = 1'b0;
                state_next = (count_reg == '0) ? S_DONE : S_XRD;
            end
            S_XRD: begin
                rd_addr    = slot_at(head_reg, k_reg - CW'(1));
                state_next = S_XEV;
            end
            S_XEV: begin
                k_next = k_reg - CW'(1);
                state_next = (k_reg == CW'(1)) ? S_DONE : S_XRD;
                if (e.answered && e.refl_public && e.fails == '0 && age_x < two_t) begin
                    if (!hit_reg) begin
                        hit_next    = 1'b1;
                        p1addr_next = e.refl_addr;
                        p1port_next = e.refl_port;
                    end else begin
                        known_next  = 1'b1;
                        stable_next = (e.refl_addr == p1addr_reg) && (e.refl_port == p1port_reg);
                        kaddr_next  = p1addr_reg;
                        kport_next  = p1port_reg;
                        ktime_next  = now_reg;
                        state_next  = S_DONE;
                    end
                end
            end
            S_DONE: begin
                if (out_load) state_next = S_IDLE;
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (wr_en) mem[wr_addr] <= wr_data;
        rd_data_reg <= mem[rd_addr];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            head_reg    <= '0;
            count_reg   <= '0;
            rate_reg    <= '0;
            lrt_reg     <= '0;
            known_reg   <= 1'b0;
            stable_reg  <= 1'b0;
            kaddr_reg   <= '0;
            kport_reg   <= '0;
            ktime_reg   <= '0;
            period_reg  <= npps_pkg::PERIOD_RESET;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg  <= state_next;
            head_reg   <= head_next;
            count_reg  <= count_next;
            rate_reg   <= rate_next;
            lrt_reg    <= lrt_next;
            known_reg  <= known_next;
            stable_reg <= stable_next;
            kaddr_reg  <= kaddr_next;
            kport_reg  <= kport_next;
            ktime_reg  <= ktime_next;
            if (psel && penable && pwrite && !paddr[2]) period_reg <= pwdata[15:0];
            if (out_load) m_valid_reg <= 1'b1;
            else if (m_ready) m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_acc) begin
            op_reg    <= s_operation;
            now_reg   <= s_now_seconds;
            paddr_reg <= s_peer_addr;
            pport_reg <= s_peer_port;
            raddr_reg <= s_reflected_addr;
            rport_reg <= s_reflected_port;
            rpub_reg  <= s_reflected_public;
        end
        k_reg         <= k_next;
        hit_reg       <= hit_next;
        p1addr_reg    <= p1addr_next;
        p1port_reg    <= p1port_next;
        prod_reg      <= prod_next;
        res_send_reg  <= res_send_next;
        res_addr_reg  <= res_addr_next;
        res_port_reg  <= res_port_next;
        res_added_reg <= res_added_next;
        res_full_reg  <= res_full_next;
        if (out_load) begin
            m_probe_send_reg <= res_send_reg;
            m_probe_addr_reg <= res_addr_reg;
            m_probe_port_reg <= res_port_reg;
            m_peer_added_reg <= res_added_reg;
            m_table_full_reg <= res_full_reg;
            m_ext_valid_reg  <= ext_ok;
            m_ext_stable_reg <= ext_ok && stable_reg;
            m_ext_ip_reg     <= ext_ok ? kaddr_reg : 32'd0;
            m_ext_port_reg   <= ext_ok ? kport_reg : 16'd0;
            m_peer_count_reg <= 5'(count_reg);
            m_need_peers_reg <= (SW'(count_reg) < SW'(npps_pkg::MIN_PEERS));
        end
    end

    assign m_valid        = m_valid_reg;
    assign m_probe_send   = m_probe_send_reg;
    assign m_probe_addr   = m_probe_addr_reg;
    assign m_probe_port   = m_probe_port_reg;
    assign m_peer_added   = m_peer_added_reg;
    assign m_table_full   = m_table_full_reg;
    assign m_ext_valid    = m_ext_valid_reg;
    assign m_ext_stable   = m_ext_stable_reg;
    assign m_ext_addr_out = m_ext_ip_reg;
    assign m_ext_port_out = m_ext_port_reg;
    assign m_peer_count   = m_peer_count_reg;
    assign m_need_peers   = m_need_peers_reg;

    `NPPS_ASSERT_NOW(a_count_bound, 1'b1, count_reg <= CW'(PEER_SLOTS))
    `NPPS_ASSERT_NOW(a_rate_bound, 1'b1, {1'b0, rate_reg} <= RATE_ONE)
    `NPPS_ASSERT_NOW(a_stable_known, stable_reg, known_reg)
    `NPPS_ASSERT_NEXT(a_load_valid, out_load, m_valid_reg && state_reg == S_IDLE)
endmodule
`default_nettype wire
